// ----- rtl/core/rsra_pkg.sv -----
// Shared constants, state encoding and control bundles for the running average unit.
package rsra_pkg;

   localparam int IMAGE_WIDTH  = 64;
   localparam int IMAGE_HEIGHT = 64;
   localparam int MAX_PLANES   = 15;
   localparam int HALF_PLANES  = MAX_PLANES / 2;
   localparam int VOXELS       = MAX_PLANES * IMAGE_HEIGHT * IMAGE_WIDTH;
   localparam int ADDR_W       = $clog2(VOXELS);
   localparam int WORD_W       = 48;
   localparam int PROD_W       = 24;

   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(VOXELS - 1);
   localparam logic [15:0]       HIT_LIMIT    = 16'hFFFF;
   localparam logic [3:0]        PLANES_RESET = 4'd9;
   localparam logic              CMD_SPLAT    = 1'b0;
   localparam logic              CMD_READ     = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_TARGET,
      ST_PROBE,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic plane_first;
      logic plane_next;
      logic target_load;
      logic mem_read;
      logic mul_load;
      logic div_init;
      logic div_step;
      logic mem_write;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic item_read;
      logic alpha_zero;
      logic target_ok;
      logic plane_last;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/core/rsra_ctrl.sv -----
// Controller state machine sequencing clear, splat and read requests.
module rsra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rsra_pkg::dp_status_type status,
   output rsra_pkg::dp_cmd_type   cmd
);
   import rsra_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.item_read) begin
               state_in = ST_TARGET;
            end else if (status.alpha_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.plane_first = 1'b1;
               state_in        = ST_TARGET;
            end
         end
         ST_TARGET: begin
            cmd.target_load = 1'b1;
            state_in        = ST_PROBE;
         end
         ST_PROBE: begin
            if (status.item_read) begin
               cmd.mem_read = status.target_ok;
               state_in     = ST_RESP;
            end else if (status.target_ok) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_MUL;
            end else if (status.plane_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.plane_next = 1'b1;
               state_in       = ST_TARGET;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            if (status.plane_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.plane_next = 1'b1;
               state_in       = ST_TARGET;
            end
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/rsra_datapath.sv -----
// Datapath: request register, plane walk, voxel memory, multiply and divide, output register.
module rsra_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  rsra_pkg::dp_cmd_type   cmd,
   output rsra_pkg::dp_status_type status,
   input  logic                   req_tuser,
   input  logic [55:0]            req_tdata,
   input  logic                   csr_wr_en,
   input  logic [3:0]             csr_wr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata
);
   import rsra_pkg::*;

   logic [3:0]              planes_ff;
   logic [ADDR_W-1:0]       clear_cnt_ff;

   logic                    item_cmd_ff;
   logic [5:0]              col_ff;
   logic [5:0]              row_ff;
   logic signed [3:0]       xs_ff;
   logic signed [3:0]       ys_ff;
   logic signed [3:0]       plane_ff;
   logic [7:0]              sample_ff [4];

   logic signed [3:0]       z_ff;
   logic [ADDR_W-1:0]       slot_ff;
   logic                    ok_ff;

   logic [WORD_W-1:0]       mem [VOXELS];
   logic [WORD_W-1:0]       rd_ff;

   logic [PROD_W-1:0]       prod_ff [4];
   logic [15:0]             n_ff;
   logic [PROD_W-1:0]       rem_ff [4];
   logic [PROD_W-1:0]       dsh_ff;
   logic [7:0]              q_ff [4];
   logic [2:0]              div_cnt_ff;

   logic                    rsp_valid_ff;
   logic [47:0]             rsp_data_ff;

   logic [2:0]              half;
   logic signed [3:0]       half_s;
   logic signed [3:0]       z_sel;
   logic signed [7:0]       dx;
   logic signed [7:0]       dy;
   logic signed [8:0]       tx;
   logic signed [8:0]       ty;
   logic                    ok_in;
   logic [ADDR_W-1:0]       slot_in;
   logic [15:0]             hits_new;
   logic [WORD_W-1:0]       wr_word;
   logic                    we;
   logic [ADDR_W-1:0]       waddr;
   logic [WORD_W-1:0]       wdata;

   assign half   = (planes_ff[3:1] > 3'(HALF_PLANES)) ? 3'(HALF_PLANES) : planes_ff[3:1];
   assign half_s = $signed({1'b0, half});

   assign z_sel = (item_cmd_ff == CMD_READ) ? plane_ff : z_ff;
   assign dx    = (item_cmd_ff == CMD_READ) ? 8'sd0 : 8'(xs_ff) * 8'(z_sel);
   assign dy    = (item_cmd_ff == CMD_READ) ? 8'sd0 : 8'(ys_ff) * 8'(z_sel);
   assign tx    = $signed({3'b000, col_ff}) + 9'(dx);
   assign ty    = $signed({3'b000, row_ff}) + 9'(dy);
   assign ok_in = (tx >= 0) && (tx < IMAGE_WIDTH) && (ty >= 0) && (ty < IMAGE_HEIGHT)
                  && (z_sel >= -HALF_PLANES) && (z_sel <= HALF_PLANES);
   assign slot_in = ADDR_W'((int'(z_sel) + HALF_PLANES) * IMAGE_HEIGHT * IMAGE_WIDTH
                            + int'(ty) * IMAGE_WIDTH + int'(tx));

   assign hits_new = (n_ff == HIT_LIMIT) ? n_ff : n_ff + 16'd1;
   assign wr_word  = {hits_new, q_ff[3], q_ff[2], q_ff[1], q_ff[0]};
   assign we       = cmd.clear_step | cmd.mem_write;
   assign waddr    = cmd.clear_step ? clear_cnt_ff : slot_ff;
   assign wdata    = cmd.clear_step ? '0 : wr_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff    <= PLANES_RESET;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            planes_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_cmd_ff  <= req_tuser;
         col_ff       <= req_tdata[5:0];
         row_ff       <= req_tdata[11:6];
         xs_ff        <= req_tdata[15:12];
         ys_ff        <= req_tdata[19:16];
         plane_ff     <= req_tdata[23:20];
         sample_ff[0] <= req_tdata[31:24];
         sample_ff[1] <= req_tdata[39:32];
         sample_ff[2] <= req_tdata[47:40];
         sample_ff[3] <= req_tdata[55:48];
      end
      if (cmd.plane_first) begin
         z_ff <= -half_s;
      end else if (cmd.plane_next) begin
         z_ff <= z_ff + 4'sd1;
      end
      if (cmd.target_load) begin
         slot_ff <= slot_in;
         ok_ff   <= ok_in;
      end
      if (cmd.mul_load) begin
         n_ff <= rd_ff[47:32];
      end
      if (cmd.div_init) begin
         dsh_ff     <= {17'(n_ff) + 17'd1, 7'b0};
         div_cnt_ff <= 3'd7;
      end else if (cmd.div_step) begin
         dsh_ff     <= dsh_ff >> 1;
         div_cnt_ff <= div_cnt_ff - 3'd1;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= ok_ff ? rd_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         if (cmd.mul_load) begin
            prod_ff[c] <= PROD_W'(rd_ff[8*c +: 8]) * PROD_W'(rd_ff[47:32]);
         end
         if (cmd.div_init) begin
            rem_ff[c] <= prod_ff[c] + PROD_W'(sample_ff[c]);
         end else if (cmd.div_step) begin
            if (rem_ff[c] >= dsh_ff) begin
               rem_ff[c] <= rem_ff[c] - dsh_ff;
               q_ff[c]   <= {q_ff[c][6:0], 1'b1};
            end else begin
               q_ff[c]   <= {q_ff[c][6:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[slot_ff];
      end
   end

   assign status.clear_last = (clear_cnt_ff == LAST_ADDR);
   assign status.item_read  = (item_cmd_ff == CMD_READ);
   assign status.alpha_zero = (sample_ff[3] == 8'd0);
   assign status.target_ok  = ok_ff;
   assign status.plane_last = (z_ff == half_s);
   assign status.div_last   = (div_cnt_ff == 3'd0);
   assign status.out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/ray_splat_running_average_unit.sv -----
// Top level of the ray splat running average unit: controller plus datapath.
// Splats RGBA ray samples into a 15 x 64 x 64 voxel volume as per-voxel running averages
// and answers voxel reads with the average and a saturating hit count. After reset the
// unit zeroes the voxel memory, one entry a cycle, and takes no request until that is
// done; configuration writes are taken at any time. One request is processed at a time.
// A read passes the decode, target, probe and response states and waits in the last
// while an earlier result is still held. A zero-alpha splat stops in decode;
// otherwise each of up to 15 planes passes target and probe, and one inside the image
// then reads, multiplies, runs the divider and writes: a read-modify-write on the single
// voxel memory around an 8-step restoring divider that yields one quotient bit per cycle
// for all four channels. A finished read result waits in an output register while the
// next request is accepted.
module ray_splat_running_average_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // command
   input  logic [55:0] req_tdata,   // column, row, x_shift, y_shift, plane, sample_red,
                                    // sample_green, sample_blue, sample_alpha
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // voxel_red, voxel_green, voxel_blue, voxel_alpha,
                                    // voxel_hits
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data  // planes_in_use
);
   import rsra_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   rsra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   rsra_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(dp_cmd.mem_write || dp_cmd.clear_step))
      else $error("voxel memory written while a request is accepted");

   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rsp_load |-> dp_status.out_free)
      else $error("result loaded over a pending result");

   a_write_in_volume: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.mem_write |-> dp_status.target_ok && !dp_status.item_read)
      else $error("splat write to a target outside the volume");

   a_div_before_write: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.mem_write |-> $past(dp_cmd.div_step) && $past(dp_status.div_last))
      else $error("splat write before the divider finished");

endmodule

// ----- dv/ray_splat_running_average_checker.sv -----
// Checker for the ray splat running average unit: predicts voxel reads and compares responses.
module ray_splat_running_average_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output int unsigned pending_reads,
   output int unsigned failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import rsra_pkg::*;

   typedef struct packed {
      logic [7:0]        alpha;
      logic [7:0]        blue;
      logic [7:0]        green;
      logic [7:0]        red;
      logic signed [3:0] plane;
      logic signed [3:0] y_shift;
      logic signed [3:0] x_shift;
      logic [5:0]        row;
      logic [5:0]        column;
   } voxel_request_type;

   logic [31:0] rgba_avg  [VOXELS];
   logic [15:0] hit_count [VOXELS];
   logic [3:0]  planes_in_use;
   logic [47:0] expected_voxels [$];
   string       channel_names [4];

   initial begin
      failures      = 0;
      pending_reads = 0;
      planes_in_use = PLANES_RESET;
      channel_names[0] = "voxel_red";
      channel_names[1] = "voxel_green";
      channel_names[2] = "voxel_blue";
      channel_names[3] = "voxel_alpha";
      for (int i = 0; i < VOXELS; i++) begin
         rgba_avg[i]  = '0;
         hit_count[i] = '0;
      end
   end

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      failures++;
   endtask

   function automatic bit locate_voxel(int x, int y, int z, output int unsigned slot);
      slot = 0;
      if (x < 0 || x >= IMAGE_WIDTH || y < 0 || y >= IMAGE_HEIGHT) return 1'b0;
      if (z < -HALF_PLANES || z > HALF_PLANES) return 1'b0;
      slot = ((z + HALF_PLANES) * IMAGE_HEIGHT + y) * IMAGE_WIDTH + x;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : track_voxels
      voxel_request_type item;
      int                half;
      int                tx;
      int                ty;
      int unsigned       slot;
      int unsigned       n;
      logic [31:0]       sample_rgba;
      logic [31:0]       old_rgba;
      logic [31:0]       new_rgba;
      logic [47:0]       want;

      if (reset) begin
         planes_in_use = PLANES_RESET;
         expected_voxels.delete();
      end else begin
         if (csr_wr_en) planes_in_use = csr_wr_data;

         if (rsp_tvalid && rsp_tready) begin
            if (expected_voxels.size() == 0) begin
               report_mismatch("response with no read outstanding", rsp_tdata, '0);
            end else begin
               want = expected_voxels.pop_front();
               for (int c = 0; c < 4; c++)
                  if (rsp_tdata[8*c +: 8] != want[8*c +: 8])
                     report_mismatch(channel_names[c], 48'(rsp_tdata[8*c +: 8]),
                                     48'(want[8*c +: 8]));
               if (rsp_tdata[47:32] != want[47:32])
                  report_mismatch("voxel_hits", 48'(rsp_tdata[47:32]), 48'(want[47:32]));
            end
         end

         if (req_tvalid && req_tready) begin
            item = req_tdata;
            if (req_tuser == CMD_SPLAT) begin
               sample_rgba = {item.alpha, item.blue, item.green, item.red};
               if (item.alpha != 0) begin
                  half = int'(planes_in_use) / 2;
                  if (half > HALF_PLANES) half = HALF_PLANES;
                  for (int z = -half; z <= half; z++) begin
                     tx = int'(item.column) + $signed(item.x_shift) * z;
                     ty = int'(item.row) + $signed(item.y_shift) * z;
                     if (locate_voxel(tx, ty, z, slot)) begin
                        n        = 32'(hit_count[slot]);
                        old_rgba = rgba_avg[slot];
                        for (int c = 0; c < 4; c++)
                           new_rgba[8*c +: 8] = 8'((32'(old_rgba[8*c +: 8]) * n
                                                    + 32'(sample_rgba[8*c +: 8])) / (n + 1));
                        rgba_avg[slot] = new_rgba;
                        if (n < HIT_LIMIT) hit_count[slot] = 16'(n + 1);
                     end
                  end
               end
            end else begin
               if (locate_voxel(int'(item.column), int'(item.row), $signed(item.plane), slot))
                  want = {hit_count[slot], rgba_avg[slot]};
               else
                  want = '0;
               expected_voxels.push_back(want);
            end
         end
      end
      pending_reads <= expected_voxels.size();
   end

endmodule

// ----- dv/ray_splat_running_average_unit_test.sv -----
// Testbench top for the ray splat running average unit: stimulus, flow control and verdict.
module ray_splat_running_average_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rsra_pkg::*;

   localparam int CYCLE_LIMIT     = 5_000_000;
   localparam int SETTLE_CYCLES   = 200;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic        req_tuser   = 1'b0;
   logic [55:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   int unsigned pending_reads;
   int unsigned failures;
   int unsigned cycle_count   = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          plane_settings [6];

   ray_splat_running_average_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ray_splat_running_average_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .pending_reads (pending_reads),
      .failures      (failures)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [55:0] pack_request(int col, int row, int xs, int ys, int pl,
                                                int r, int g, int b, int a);
      return {a[7:0], b[7:0], g[7:0], r[7:0], pl[3:0], ys[3:0], xs[3:0], row[5:0], col[5:0]};
   endfunction

   task automatic send_request(logic cmd, logic [55:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic splat(int col, int row, int xs, int ys, int r, int g, int b, int a);
      send_request(CMD_SPLAT, pack_request(col, row, xs, ys, $urandom_range(15), r, g, b, a));
   endtask

   task automatic read_voxel(int col, int row, int pl);
      send_request(CMD_READ, pack_request(col, row, $urandom_range(15), $urandom_range(15), pl,
                                          $urandom_range(255), $urandom_range(255),
                                          $urandom_range(255), $urandom_range(255)));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_reads != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_planes(int value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[3:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(int count);
      int origin_col = 32;
      int origin_row = 32;
      int shift_x    = 0;
      int shift_y    = 0;
      int z;

      repeat (count) begin
         if ($urandom_range(99) < 40) begin
            if ($urandom_range(99) < 70) begin
               z = $urandom_range(14) - 7;
               read_voxel((origin_col + shift_x * z) & 63, (origin_row + shift_y * z) & 63, z);
            end else begin
               read_voxel($urandom_range(63), $urandom_range(63), $urandom_range(15));
            end
         end else begin
            if ($urandom_range(99) < 70) begin
               origin_col = $urandom_range(39, 24);
               origin_row = $urandom_range(39, 24);
            end else begin
               origin_col = $urandom_range(63);
               origin_row = $urandom_range(63);
            end
            if ($urandom_range(99) < 85) begin
               shift_x = int'($urandom_range(8)) - 4;
               shift_y = int'($urandom_range(8)) - 4;
            end else begin
               shift_x = int'($urandom_range(15)) - 8;
               shift_y = int'($urandom_range(15)) - 8;
            end
            splat(origin_col, origin_row, shift_x, shift_y,
                  $urandom_range(255), $urandom_range(255), $urandom_range(255),
                  ($urandom_range(9) == 0) ? 0 : $urandom_range(255, 1));
         end
      end
   endtask

   initial begin
      plane_settings = '{15, 2, 7, 0, 13, 4};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      splat(0, 0, 0, 0, 255, 0, 128, 255);
      read_voxel(0, 0, 0);
      read_voxel(0, 0, 4);
      read_voxel(0, 0, -5);
      read_voxel(0, 0, -8);
      splat(0, 0, 0, 0, 9, 9, 9, 0);
      splat(0, 0, 0, 0, 0, 255, 1, 1);
      read_voxel(0, 0, 0);
      splat(63, 63, 7, -8, 1, 2, 3, 1);
      read_voxel(63, 63, 0);
      splat(32, 32, 4, -4, 200, 100, 50, 25);
      read_voxel(40, 24, 2);
      read_voxel(16, 48, -4);
      splat(5, 60, -8, 7, 77, 88, 99, 111);
      read_voxel(5, 60, 0);
      read_voxel(63, 0, 7);

      write_planes(15);
      splat(32, 32, 1, 1, 10, 20, 30, 40);
      read_voxel(39, 39, 7);
      read_voxel(25, 25, -7);
      read_voxel(32, 32, 0);

      write_planes(0);
      splat(20, 20, 3, 3, 255, 255, 255, 255);
      read_voxel(20, 20, 0);
      read_voxel(23, 23, 1);

      write_planes(6);
      splat(10, 10, 1, 0, 60, 70, 80, 90);
      read_voxel(13, 10, 3);

      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 13 : (seg < 4) ? 83 : 0;
         recv_idle_pct = (seg < 2) ? 83 : (seg < 4) ? 13 : 0;
         write_planes(plane_settings[seg]);
         run_random(125);
      end

      drain();
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
